// ===== hw/rtl/prl_pkg.sv =====
`default_nettype none

package prl_pkg;

  // fixed field widths
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned CLAUSE_W   = 9;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned PSTART_W   = 32;
  localparam int unsigned TSIZE_W    = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // parameter defaults
  localparam int unsigned DEF_ENTRIES   = 256;
  localparam int unsigned DEF_ADDR_BITS = 32;
  localparam int unsigned DEF_NAME_BITS = 16;

  // command codes carried in tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // region kinds
  localparam logic [KIND_W-1:0] KIND_FUNC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KERNEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BEYOND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE    = 2'd1;

  // control part of the search token passed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
    logic traced;
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prl_cell.sv =====
`default_nettype none

module prl_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned ADDR_BITS = prl_pkg::DEF_ADDR_BITS,
  parameter int unsigned NAME_BITS = prl_pkg::DEF_NAME_BITS,
  parameter int unsigned CNT_W     = 9
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // entry load, broadcast to all cells
  input  wire                                wr_en_i,
  input  wire  [prl_pkg::SLOT_W-1:0]         wr_slot_i,
  input  wire  [ADDR_BITS-1:0]               wr_end_i,
  input  wire  [NAME_BITS-1:0]               wr_name_i,
  input  wire                                wr_trace_i,
  // lookup context; the user must keep it stable while a token travels, the cell does not enforce it
  input  wire  [ADDR_BITS-1:0]               addr_i,
  input  wire  [CNT_W-1:0]                   used_i,
  // token from the left neighbor
  input  wire  prl_pkg::tok_ctl_t            tok_ctl_i,
  input  wire  [prl_pkg::CLAUSE_W-1:0]       tok_clause_i,
  input  wire  [NAME_BITS-1:0]               tok_name_i,
  // token to the right neighbor
  output prl_pkg::tok_ctl_t                  tok_ctl_o,
  output logic [prl_pkg::CLAUSE_W-1:0]       tok_clause_o,
  output logic [NAME_BITS-1:0]               tok_name_o
);

  logic [ADDR_BITS-1:0]         end_q;
  logic [NAME_BITS-1:0]         name_q;
  logic                         trace_q;
  logic                         slot_hit;
  logic                         active;
  logic                         same_run;
  prl_pkg::tok_ctl_t            ctl_d, ctl_q;
  logic [prl_pkg::CLAUSE_W-1:0] clause_d, clause_q;
  logic [NAME_BITS-1:0]         tname_d, tname_q;

  // this cell's entry, written when a load targets its slot
  assign slot_hit = (IDX < (2 ** prl_pkg::SLOT_W)) &&
                    (wr_slot_i == IDX[prl_pkg::SLOT_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && slot_hit) begin
      end_q   <= wr_end_i;
      name_q  <= wr_name_i;
      trace_q <= wr_trace_i;
    end
  end

  // search step: count the run of equal names, stop at the first end >= addr
  assign active   = tok_ctl_i.valid && !tok_ctl_i.hit && (CNT_W'(IDX) < used_i);
  assign same_run = (IDX != 0) && (name_q == tok_name_i);

  always_comb begin
    ctl_d    = tok_ctl_i;
    clause_d = tok_clause_i;
    tname_d  = tok_name_i;
    if (active) begin
      clause_d = same_run ? (tok_clause_i + prl_pkg::CLAUSE_W'(1)) : prl_pkg::CLAUSE_W'(1);
      tname_d  = name_q;
      if (end_q >= addr_i) begin
        ctl_d.hit    = 1'b1;
        ctl_d.traced = trace_q;
      end
    end
  end

  // token control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    clause_q <= clause_d;
    tname_q  <= tname_d;
  end

  assign tok_ctl_o    = ctl_q;
  assign tok_clause_o = clause_q;
  assign tok_name_o   = tname_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pc_region_lookup_core.sv =====
`default_nettype none

// Region lookup over a table of code regions held in a row of ENTRIES cells,
// one entry per cell. A load beat writes one cell. A lookup beat launches a
// search token that walks the row one cell per clock, so a lookup occupies
// the block from acceptance through a launch register, ENTRIES cells and a
// staging register, independent of table_size. The finished result moves
// from the staging register into the output register, so the next beat is
// accepted while that result still waits there; any finished result that is
// still in the staging register holds the input off. Loads go to slots below
// ENTRIES; only the low TSIZE_W bits of table_size are used, and a value
// above ENTRIES counts as ENTRIES.
module pc_region_lookup_core #(
  parameter int unsigned ENTRIES   = prl_pkg::DEF_ENTRIES,
  parameter int unsigned ADDR_BITS = prl_pkg::DEF_ADDR_BITS,
  parameter int unsigned NAME_BITS = prl_pkg::DEF_NAME_BITS,
  localparam int unsigned IN_BITS  = prl_pkg::SLOT_W + ADDR_BITS + NAME_BITS + 1 + ADDR_BITS,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = NAME_BITS + prl_pkg::CLAUSE_W + 1,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_slot, end_address, region_name, trace_mark, address, zero fill
  input  wire  [IN_W-1:0]                  s_axis_tdata,
  // cmd
  input  wire  [0:0]                       s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // found_name, clause_number, traced, zero fill
  output logic [OUT_W-1:0]                 m_axis_tdata,
  // region_kind
  output logic [prl_pkg::KIND_W-1:0]       m_axis_tuser,
  // configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [prl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [prl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned END_LO  = prl_pkg::SLOT_W;
  localparam int unsigned NAME_LO = END_LO + ADDR_BITS;
  localparam int unsigned TRC_LO  = NAME_LO + NAME_BITS;
  localparam int unsigned ADR_LO  = TRC_LO + 1;

  // input fields
  logic [prl_pkg::SLOT_W-1:0] in_slot;
  logic [ADDR_BITS-1:0]       in_end;
  logic [NAME_BITS-1:0]       in_name;
  logic                       in_trace;
  logic [ADDR_BITS-1:0]       in_addr;
  logic                       in_cmd;
  logic                       in_beat;
  logic                       load_beat;
  logic                       lookup_beat;

  assign in_slot  = s_axis_tdata[prl_pkg::SLOT_W-1:0];
  assign in_end   = s_axis_tdata[END_LO +: ADDR_BITS];
  assign in_name  = s_axis_tdata[NAME_LO +: NAME_BITS];
  assign in_trace = s_axis_tdata[TRC_LO];
  assign in_addr  = s_axis_tdata[ADR_LO +: ADDR_BITS];
  assign in_cmd   = s_axis_tuser[0];

  // control and configuration state
  logic                           busy_q;
  logic                           start_q;
  logic                           pend_vld_q;
  logic                           out_vld_q;
  logic [prl_pkg::PSTART_W-1:0]   pstart_q;
  logic [CNT_W-1:0]               used_q;
  logic [ADDR_BITS-1:0]           addr_q;
  logic                           below_q;

  // result staging
  logic [prl_pkg::KIND_W-1:0]     pend_kind_q, out_kind_q;
  logic [NAME_BITS-1:0]           pend_name_q, out_name_q;
  logic [prl_pkg::CLAUSE_W-1:0]   pend_clause_q, out_clause_q;
  logic                           pend_trc_q, out_trc_q;

  logic                           out_free;
  logic                           chain_done;
  logic [prl_pkg::TSIZE_W-1:0]    cfg_tsize;
  logic [CNT_W-1:0]               used_d;

  assign s_axis_tready = !busy_q && !pend_vld_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign load_beat     = in_beat && (in_cmd == prl_pkg::CMD_LOAD);
  assign lookup_beat   = in_beat && (in_cmd == prl_pkg::CMD_LOOKUP);
  assign out_free      = !out_vld_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // clamp the table size to the number of cells
  assign cfg_tsize = cfg_data_i[prl_pkg::TSIZE_W-1:0];
  assign used_d    = (32'(cfg_tsize) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(cfg_tsize);

  // token chain wiring
  prl_pkg::tok_ctl_t              ctl_w    [ENTRIES+1];
  logic [prl_pkg::CLAUSE_W-1:0]   clause_w [ENTRIES+1];
  logic [NAME_BITS-1:0]           name_w   [ENTRIES+1];

  assign ctl_w[0].valid  = start_q;
  assign ctl_w[0].hit    = 1'b0;
  assign ctl_w[0].traced = 1'b0;
  assign clause_w[0]     = prl_pkg::CLAUSE_W'(1);
  assign name_w[0]       = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    prl_cell #(
      .IDX       (g),
      .ADDR_BITS (ADDR_BITS),
      .NAME_BITS (NAME_BITS),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_en_i      (load_beat),
      .wr_slot_i    (in_slot),
      .wr_end_i     (in_end),
      .wr_name_i    (in_name),
      .wr_trace_i   (in_trace),
      .addr_i       (addr_q),
      .used_i       (used_q),
      .tok_ctl_i    (ctl_w[g]),
      .tok_clause_i (clause_w[g]),
      .tok_name_i   (name_w[g]),
      .tok_ctl_o    (ctl_w[g+1]),
      .tok_clause_o (clause_w[g+1]),
      .tok_name_o   (name_w[g+1])
    );
  end

  assign chain_done = ctl_w[ENTRIES].valid;

  // control, configuration and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      start_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      pstart_q   <= '0;
      used_q     <= '0;
    end else begin
      start_q <= lookup_beat;
      if (lookup_beat) begin
        busy_q <= 1'b1;
      end else if (chain_done) begin
        busy_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= pend_vld_q;
      end
      if (chain_done) begin
        pend_vld_q <= 1'b1;
      end else if (out_free) begin
        pend_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          prl_pkg::REG_PROGRAM_START: pstart_q <= cfg_data_i[prl_pkg::PSTART_W-1:0];
          prl_pkg::REG_TABLE_SIZE:    used_q   <= used_d;
          default: ;
        endcase
      end
    end
  end

  // lookup context and result payload
  always_ff @(posedge clk_i) begin
    if (lookup_beat) begin
      addr_q  <= in_addr;
      below_q <= 64'(in_addr) < 64'(pstart_q);
    end
    if (chain_done) begin
      pend_trc_q <= ctl_w[ENTRIES].hit ? ctl_w[ENTRIES].traced : 1'b1;
      if (below_q) begin
        pend_kind_q   <= prl_pkg::KIND_KERNEL;
        pend_name_q   <= '0;
        pend_clause_q <= prl_pkg::CLAUSE_W'(1);
      end else if (ctl_w[ENTRIES].hit) begin
        pend_kind_q   <= prl_pkg::KIND_FUNC;
        pend_name_q   <= name_w[ENTRIES];
        pend_clause_q <= clause_w[ENTRIES];
      end else begin
        pend_kind_q   <= prl_pkg::KIND_BEYOND;
        pend_name_q   <= '0;
        pend_clause_q <= prl_pkg::CLAUSE_W'(1);
      end
    end
    if (out_free && pend_vld_q) begin
      out_kind_q   <= pend_kind_q;
      out_name_q   <= pend_name_q;
      out_clause_q <= pend_clause_q;
      out_trc_q    <= pend_trc_q;
    end
  end

  // result beat
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = OUT_W'({out_trc_q, out_clause_q, out_name_q});

endmodule

`default_nettype wire

// ===== hw/rtl/prl_checker.sv =====
`default_nettype none

module prl_checker #(
  parameter int unsigned OUT_W     = 32,
  parameter int unsigned NAME_BITS = prl_pkg::DEF_NAME_BITS
) (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire [0:0]                      s_axis_tuser,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [OUT_W-1:0]                m_axis_tdata,
  input wire [prl_pkg::KIND_W-1:0]      m_axis_tuser
);

  localparam int unsigned CL_LO = NAME_BITS;
  localparam int unsigned TR_BIT = NAME_BITS + prl_pkg::CLAUSE_W;

  // a stalled result beat holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // only a function hit reports a name and a clause past the first
  a_non_func_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != prl_pkg::KIND_FUNC) |->
      (m_axis_tdata[NAME_BITS-1:0] == '0) &&
      (m_axis_tdata[CL_LO +: prl_pkg::CLAUSE_W] == prl_pkg::CLAUSE_W'(1)))
    else $error("non-function result carries name or clause");

  // a beyond-table result (a search with no hit) is always reported traced
  a_beyond_traced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == prl_pkg::KIND_BEYOND) |-> m_axis_tdata[TR_BIT])
    else $error("beyond-table result not traced");

  // a lookup blocks the input while its token walks the cells
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == prl_pkg::CMD_LOOKUP) |=>
      !s_axis_tready)
    else $error("input accepted during a lookup");

  // clause number never reads zero
  a_clause_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CL_LO +: prl_pkg::CLAUSE_W] != '0))
    else $error("zero clause number");

endmodule

bind pc_region_lookup_core prl_checker #(
  .OUT_W     (OUT_W),
  .NAME_BITS (NAME_BITS)
) u_prl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/tb_pc_region_lookup_core.sv =====
`default_nettype none

module tb_pc_region_lookup_core;

  localparam int unsigned ENTRIES   = prl_pkg::DEF_ENTRIES;
  localparam int unsigned ADDR_W    = prl_pkg::DEF_ADDR_BITS;
  localparam int unsigned NAME_W    = prl_pkg::DEF_NAME_BITS;
  localparam int unsigned IN_BITS   = prl_pkg::SLOT_W + ADDR_W + NAME_W + 1 + ADDR_W;
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = NAME_W + prl_pkg::CLAUSE_W + 1;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned ITEM_GOAL     = 1100;
  localparam int unsigned LIMIT_CYCLES  = 3_000_000;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned SETTLE_CYCLES = ENTRIES + 8;

  // register indexes with no register behind them
  localparam logic [prl_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [prl_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                         cmd;
    logic [prl_pkg::SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]            end_addr;
    logic [NAME_W-1:0]            name;
    logic                         trace;
    logic [ADDR_W-1:0]            pc;
  } beat_t;

  typedef struct packed {
    logic [prl_pkg::KIND_W-1:0]   kind;
    logic [NAME_W-1:0]            name;
    logic [prl_pkg::CLAUSE_W-1:0] clause;
    logic                         traced;
  } region_t;

  logic clk_i;
  logic rst_ni;

  logic                           in_valid;
  logic                           in_ready;
  logic [IN_W-1:0]                in_data;
  logic [0:0]                     in_user;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [OUT_W-1:0]               out_data;
  logic [prl_pkg::KIND_W-1:0]     out_user;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [prl_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state: registers and region table as the block should hold them
  logic [prl_pkg::PSTART_W-1:0] pstart_q;
  logic [prl_pkg::TSIZE_W-1:0]  tsize_q;
  logic [ADDR_W-1:0]   end_tbl   [ENTRIES];
  logic [NAME_W-1:0]   name_tbl  [ENTRIES];
  logic                trace_tbl [ENTRIES];

  region_t pending_regions[$];
  region_t want_r;
  region_t got_r;

  int mismatches = 0;
  int beats = 0;
  int loads = 0;
  int lookups = 0;
  int reg_writes = 0;
  int kind_count[3] = '{0, 0, 0};
  int phases = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // receiver hold-off request and its own counters
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  pc_region_lookup_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_user),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tuser  (out_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_regions.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result side stalls: random stretches of modes, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left <= $urandom_range(16, 300);
        rx_mode <= $urandom_range(0, 2);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      got_r.kind   = out_user;
      got_r.name   = out_data[NAME_W-1:0];
      got_r.clause = out_data[NAME_W +: prl_pkg::CLAUSE_W];
      got_r.traced = out_data[NAME_W + prl_pkg::CLAUSE_W];
      if (pending_regions.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: kind %0d name %h clause %0d traced %b",
                 $time, got_r.kind, got_r.name, got_r.clause, got_r.traced);
      end else begin
        want_r = pending_regions.pop_front();
        if (got_r.kind !== want_r.kind) begin
          mismatches++;
          $display("%0t: region_kind expected %0d got %0d", $time, want_r.kind, got_r.kind);
        end
        if (got_r.name !== want_r.name) begin
          mismatches++;
          $display("%0t: found_name expected %h got %h", $time, want_r.name, got_r.name);
        end
        if (got_r.clause !== want_r.clause) begin
          mismatches++;
          $display("%0t: clause_number expected %0d got %0d", $time, want_r.clause,
                   got_r.clause);
        end
        if (got_r.traced !== want_r.traced) begin
          mismatches++;
          $display("%0t: traced expected %b got %b", $time, want_r.traced, got_r.traced);
        end
      end
    end
  end

  // expected classification of one program counter against the table
  function automatic region_t classify_pc(input logic [ADDR_W-1:0] pc);
    region_t r;
    int used;
    int i;
    int hit_idx;
    bit hit;
    logic [prl_pkg::CLAUSE_W-1:0] clause;
    used = (tsize_q > ENTRIES) ? ENTRIES : int'(tsize_q);
    clause = 1;
    hit = 1'b0;
    hit_idx = 0;
    for (i = 0; i < used && !hit; i++) begin
      if (i == 0 || name_tbl[i] != name_tbl[i-1]) clause = 1;
      else clause = clause + 1'b1;
      if (end_tbl[i] >= pc) begin
        hit = 1'b1;
        hit_idx = i;
      end
    end
    r.traced = hit ? trace_tbl[hit_idx] : 1'b1;
    r.name = '0;
    r.clause = 1;
    if (pc < pstart_q) begin
      r.kind = prl_pkg::KIND_KERNEL;
    end else if (hit) begin
      r.kind = prl_pkg::KIND_FUNC;
      r.name = name_tbl[hit_idx];
      r.clause = clause;
    end else begin
      r.kind = prl_pkg::KIND_BEYOND;
    end
    return r;
  endfunction

  function automatic beat_t load_beat(input int slot, input logic [ADDR_W-1:0] end_addr,
                                      input logic [NAME_W-1:0] name, input logic trace);
    beat_t b;
    b.cmd = prl_pkg::CMD_LOAD;
    b.slot = slot[prl_pkg::SLOT_W-1:0];
    b.end_addr = end_addr;
    b.name = name;
    b.trace = trace;
    b.pc = $urandom;
    return b;
  endfunction

  // lookup beat; load fields carry random junk
  function automatic beat_t lookup_beat(input logic [ADDR_W-1:0] pc);
    beat_t b;
    b.cmd = prl_pkg::CMD_LOOKUP;
    b.slot = $urandom;
    b.end_addr = $urandom;
    b.name = $urandom;
    b.trace = $urandom_range(0, 1);
    b.pc = pc;
    return b;
  endfunction

  // send one beat and update the prediction once it is taken
  task automatic send_item(input beat_t b);
    region_t want;
    in_valid <= 1'b1;
    in_user <= b.cmd;
    in_data <= {{(IN_W - IN_BITS){1'b0}}, b.pc, b.trace, b.name, b.end_addr, b.slot};
    do @(posedge clk_i); while (!in_ready);
    beats++;
    if (b.cmd == prl_pkg::CMD_LOAD) begin
      end_tbl[b.slot] = b.end_addr;
      name_tbl[b.slot] = b.name;
      trace_tbl[b.slot] = b.trace;
      loads++;
    end else begin
      want = classify_pc(b.pc);
      pending_regions.push_back(want);
      kind_count[want.kind]++;
      lookups++;
    end
  endtask

  // sender bursts and gaps
  task automatic pace();
    int gap;
    int r;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 9);
      if (r < 5) gap = $urandom_range(1, 6);
      else if (r < 8) gap = $urandom_range(7, 60);
      else gap = $urandom_range(100, 300);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  // stop sending, wait for every result, then let an unfinished search run out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one config beat; valid is left high for a following write
  task automatic write_reg(input logic [prl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prl_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    reg_writes++;
    if (idx == prl_pkg::REG_PROGRAM_START) pstart_q = val;
    else if (idx == prl_pkg::REG_TABLE_SIZE) tsize_q = val[prl_pkg::TSIZE_W-1:0];
  endtask

  task automatic configure(input logic [prl_pkg::CFG_DATA_W-1:0] pstart,
                           input logic [prl_pkg::CFG_DATA_W-1:0] tsize);
    write_reg(prl_pkg::REG_PROGRAM_START, pstart);
    write_reg(prl_pkg::REG_TABLE_SIZE, tsize);
    cfg_valid <= 1'b0;
  endtask

  // lookup address near the interesting points of the current table
  function automatic logic [ADDR_W-1:0] pick_pc(input int used);
    int k;
    if (used == 0) return ($urandom_range(0, 3) == 0) ? pstart_q : $urandom;
    k = $urandom_range(0, used - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return end_tbl[k];
      3: return end_tbl[k] + 1'b1;
      4: return end_tbl[k] - 1'b1;
      5: return pstart_q;
      6: return pstart_q - 1'b1;
      7: return end_tbl[used - 1];
      default: return $urandom;
    endcase
  endfunction

  // one table setting: configure, load an ascending table if asked, then lookups with stray loads
  task automatic random_phase(input int used, input logic [prl_pkg::CFG_DATA_W-1:0] tsize,
                              input int n_lookups, input bit long_run, input bit reload);
    logic [ADDR_W-1:0] ends [ENTRIES];
    logic [NAME_W-1:0] names [ENTRIES];
    int order [ENTRIES];
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] v;
    logic [prl_pkg::CFG_DATA_W-1:0] pstart;
    int j;
    int k;
    int t;
    settle();
    phases++;
    if (reload) begin
      case ($urandom_range(0, 3))
        0: mask = 32'h0000_00FF;
        1: mask = 32'h0000_FFFF;
        default: mask = '1;
      endcase
      if (long_run) mask = '1;
      // insertion sort keeps end addresses ascending
      for (j = 0; j < used; j++) begin
        v = $urandom & mask;
        k = j;
        while (k > 0 && ends[k-1] > v) begin
          ends[k] = ends[k-1];
          k--;
        end
        ends[k] = v;
      end
      for (j = 0; j < used; j++) begin
        if (long_run) names[j] = (j == 0) ? NAME_W'($urandom) : names[0];
        else if (j > 0 && $urandom_range(0, 2) != 0) names[j] = names[j-1];
        else names[j] = ($urandom_range(0, 1) == 1) ? NAME_W'($urandom_range(0, 3))
                                                    : NAME_W'($urandom);
        order[j] = j;
      end
      if ($urandom_range(0, 1) == 1) begin
        for (j = used - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          t = order[j];
          order[j] = order[k];
          order[k] = t;
        end
      end
    end
    case ($urandom_range(0, 7))
      0, 1, 2: pstart = '0;
      3, 4: pstart = $urandom;
      5, 6: pstart = (used == 0) ? $urandom :
                     (reload ? ends[$urandom_range(0, used - 1)]
                             : end_tbl[$urandom_range(0, used - 1)]);
      default: pstart = '1;
    endcase
    if (long_run) pstart = '0;
    configure(pstart, tsize);
    if (reload) begin
      for (j = 0; j < used; j++) begin
        k = order[j];
        pace();
        send_item(load_beat(k, ends[k], names[k], $urandom_range(0, 1)));
      end
    end
    j = 0;
    while (j < n_lookups) begin
      pace();
      if ($urandom_range(0, 9) < 3) begin
        send_item(load_beat($urandom_range(0, ENTRIES - 1), $urandom, $urandom,
                            $urandom_range(0, 1)));
      end else begin
        send_item(lookup_beat(pick_pc(used)));
        j++;
      end
    end
  endtask

  // empty table straight after reset, then writes to unused register indexes, then a program start
  task automatic test_reset_state();
    send_item(lookup_beat('0));
    send_item(lookup_beat('1));
    settle();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    cfg_valid <= 1'b0;
    send_item(lookup_beat(32'h0000_0FFF));
    send_item(lookup_beat(32'h0000_1000));
    settle();
    configure(32'h0000_1000, 32'd0);
    send_item(lookup_beat(32'h0000_0FFF));
    send_item(lookup_beat(32'h0000_1000));
  endtask

  // small hand-built table: runs of names, edge addresses, kernel and beyond cases
  task automatic test_directed_table();
    settle();
    configure(32'h0000_1000, 32'd6);
    send_item(load_beat(0, 32'h0000_0000, 16'h0000, 1'b0));
    send_item(load_beat(1, 32'h0000_1FFF, 16'hFFFF, 1'b1));
    send_item(load_beat(2, 32'h0000_2000, 16'hFFFF, 1'b0));
    send_item(load_beat(3, 32'h8000_0000, 16'hFFFF, 1'b1));
    send_item(load_beat(4, 32'hFFFF_FFFE, 16'h1234, 1'b1));
    send_item(load_beat(5, 32'hFFFF_FFFF, 16'h1234, 1'b0));
    send_item(load_beat(ENTRIES - 1, '1, '1, 1'b1));
    send_item(lookup_beat(32'h0000_0000));
    send_item(lookup_beat(32'h0000_1000));
    send_item(lookup_beat(32'h0000_2000));
    send_item(lookup_beat(32'h0000_2001));
    send_item(lookup_beat(32'hFFFF_FFFF));
    settle();
    configure(32'h0000_0000, 32'd5);
    send_item(lookup_beat(32'hFFFF_FFFF));
    send_item(lookup_beat(32'h0000_0000));
    settle();
    configure(32'hFFFF_FFFF, 32'd6);
    send_item(lookup_beat(32'hFFFF_FFFE));
    send_item(lookup_beat(32'hFFFF_FFFF));
  endtask

  // full table with one long run of a single name, then an oversized table_size
  task automatic test_full_table();
    random_phase(ENTRIES, ENTRIES, 20, 1'b1, 1'b1);
    random_phase(ENTRIES, '1, 12, 1'b0, 1'b0);
  endtask

  // result side holds off while lookups keep coming, then the sender drains
  task automatic test_output_backpressure();
    int j;
    settle();
    hold_req <= ~hold_req;
    for (j = 0; j < 8; j++) send_item(lookup_beat(pick_pc(tsize_q > ENTRIES ? ENTRIES : tsize_q)));
    settle();
  endtask

  // random tables of mostly small sizes until the item budget is spent
  task automatic test_random_tables();
    int used;
    logic [prl_pkg::CFG_DATA_W-1:0] tsize;
    while (beats < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: used = 0;
        1, 2, 3, 4, 5, 6: used = $urandom_range(1, 12);
        7, 8: used = $urandom_range(13, 64);
        default: used = $urandom_range(65, 200);
      endcase
      tsize = used;
      if ($urandom_range(0, 1) == 1) tsize = ($urandom & 32'hFFFF_FE00) | used;
      random_phase(used, tsize, $urandom_range(3, 16), 1'b0, 1'b1);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    in_user <= prl_pkg::CMD_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= prl_pkg::REG_PROGRAM_START;
    cfg_data <= '0;
    pstart_q = '0;
    tsize_q = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_table();
    test_full_table();
    test_output_backpressure();
    test_random_tables();
    settle();

    if (pending_regions.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, pending_regions.size());
    end
    $display("covered %0d beats (%0d loads, %0d lookups) over %0d random tables, %0d reg writes",
             beats, loads, lookups, phases, reg_writes);
    $display("lookup kinds: %0d function, %0d kernel, %0d beyond table",
             kind_count[prl_pkg::KIND_FUNC], kind_count[prl_pkg::KIND_KERNEL],
             kind_count[prl_pkg::KIND_BEYOND]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== pc_region_lookup_core.f =====
hw/rtl/prl_pkg.sv
hw/rtl/prl_cell.sv
hw/rtl/pc_region_lookup_core.sv
hw/rtl/prl_checker.sv
sim/tb_pc_region_lookup_core.sv
